[sv/nasie_pkg.sv]
// shared types, codes and constant tables of the nas optional element matcher
// holds the per-kind expected element lists and the microcode word layout
// no dependencies
package nasie_pkg;

	// message kinds
	localparam logic [1:0] KIND_ATTACH = 2'd0;
	localparam logic [1:0] KIND_TAU    = 2'd1;
	localparam logic [1:0] KIND_PDN    = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// element formats
	typedef enum logic [1:0] {
		FMT_TLV  = 2'd0,
		FMT_TV   = 2'd1,
		FMT_HALF = 2'd2
	} fmt_t;

	// matching phase of the current optional part
	typedef enum logic [1:0] {
		PH_ID  = 2'd0,
		PH_LEN = 2'd1,
		PH_VAL = 2'd2,
		PH_UNP = 2'd3
	} phase_t;

	// datapath action selected by a control word
	typedef enum logic [2:0] {
		A_FETCH = 3'd0,
		A_SCAN  = 3'd1,
		A_OPEN  = 3'd2,
		A_LEN   = 3'd3,
		A_BODY  = 3'd4,
		A_UNP   = 3'd5
	} act_t;

	// branch kind of a control word
	typedef enum logic [1:0] {
		BR_DISPATCH = 2'd0,
		BR_SCAN     = 2'd1,
		BR_DONE     = 2'd2
	} br_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_FETCH = 3'd0;
	localparam step_t STEP_SCAN  = 3'd1;
	localparam step_t STEP_OPEN  = 3'd2;
	localparam step_t STEP_LEN   = 3'd3;
	localparam step_t STEP_BODY  = 3'd4;
	localparam step_t STEP_UNP   = 3'd5;

	typedef struct packed {
		act_t  act;
		br_t   br;
		step_t tgt;
		step_t alt;
	} uword_t;

	typedef struct packed {
		act_t act;
	} ctrl_t;

	typedef struct packed {
		logic   in_acc;
		phase_t disp_phase;
		logic   scan_hit;
		logic   scan_end;
		logic   out_free;
	} stat_t;

	// arg: total length for tv, value mask for half-byte
	typedef struct packed {
		logic [7:0] id;
		fmt_t       fmt;
		logic [3:0] arg;
	} ie_desc_t;

	localparam logic [7:0] HALF_ID_MASK = 8'hF0;

	function automatic logic [4:0] rom_count(input logic [1:0] kind);
		logic [4:0] c;
		case (kind)
			KIND_ATTACH: c = 5'd18;
			KIND_TAU:    c = 5'd24;
			KIND_PDN:    c = 5'd4;
			default:     c = 5'd0;
		endcase
		return c;
	endfunction

	function automatic ie_desc_t ie_rom(input logic [1:0] kind, input logic [4:0] idx);
		ie_desc_t d;
		d = '{8'h00, FMT_TLV, 4'd0};
		case (kind)
			KIND_TAU: begin
				case (idx)
					5'd0:    d = '{8'h0B, FMT_HALF, 4'hF};
					5'd1:    d = '{8'h08, FMT_HALF, 4'h7};
					5'd2:    d = '{8'h19, FMT_TV, 4'd4};
					5'd3:    d = '{8'h50, FMT_TLV, 4'd0};
					5'd4:    d = '{8'h55, FMT_TV, 4'd5};
					5'd5:    d = '{8'h58, FMT_TLV, 4'd0};
					5'd6:    d = '{8'h52, FMT_TV, 4'd6};
					5'd7:    d = '{8'h5C, FMT_TV, 4'd3};
					5'd8:    d = '{8'h0A, FMT_HALF, 4'h1};
					5'd9:    d = '{8'h57, FMT_TLV, 4'd0};
					5'd10:   d = '{8'h31, FMT_TLV, 4'd0};
					5'd11:   d = '{8'h13, FMT_TV, 4'd6};
					5'd12:   d = '{8'h09, FMT_HALF, 4'h1};
					5'd13:   d = '{8'h11, FMT_TLV, 4'd0};
					5'd14:   d = '{8'h20, FMT_TLV, 4'd0};
					5'd15:   d = '{8'h40, FMT_TLV, 4'd0};
					5'd16:   d = '{8'h0F, FMT_HALF, 4'h1};
					5'd17:   d = '{8'h5D, FMT_TLV, 4'd0};
					5'd18:   d = '{8'h0E, FMT_HALF, 4'h1};
					5'd19:   d = '{8'h0D, FMT_HALF, 4'h1};
					5'd20:   d = '{8'h0C, FMT_HALF, 4'h1};
					5'd21:   d = '{8'h10, FMT_TLV, 4'd0};
					5'd22:   d = '{8'h6A, FMT_TLV, 4'd0};
					5'd23:   d = '{8'h5E, FMT_TLV, 4'd0};
					default: d = '{8'h00, FMT_TLV, 4'd0};
				endcase
			end
			KIND_PDN: begin
				case (idx)
					5'd0:    d = '{8'h0D, FMT_HALF, 4'h1};
					5'd1:    d = '{8'h28, FMT_TLV, 4'd0};
					5'd2:    d = '{8'h27, FMT_TLV, 4'd0};
					5'd3:    d = '{8'h0C, FMT_HALF, 4'h1};
					default: d = '{8'h00, FMT_TLV, 4'd0};
				endcase
			end
			default: begin
				case (idx)
					5'd0:    d = '{8'h19, FMT_TV, 4'd4};
					5'd1:    d = '{8'h50, FMT_TLV, 4'd0};
					5'd2:    d = '{8'h52, FMT_TV, 4'd6};
					5'd3:    d = '{8'h5C, FMT_TV, 4'd3};
					5'd4:    d = '{8'h31, FMT_TLV, 4'd0};
					5'd5:    d = '{8'h13, FMT_TV, 4'd6};
					5'd6:    d = '{8'h09, FMT_HALF, 4'h1};
					5'd7:    d = '{8'h11, FMT_TLV, 4'd0};
					5'd8:    d = '{8'h20, FMT_TLV, 4'd0};
					5'd9:    d = '{8'h40, FMT_TLV, 4'd0};
					5'd10:   d = '{8'h0F, FMT_HALF, 4'h1};
					5'd11:   d = '{8'h5D, FMT_TLV, 4'd0};
					5'd12:   d = '{8'h0D, FMT_HALF, 4'h1};
					5'd13:   d = '{8'h0E, FMT_HALF, 4'h1};
					5'd14:   d = '{8'h0C, FMT_HALF, 4'h1};
					5'd15:   d = '{8'h10, FMT_TLV, 4'd0};
					5'd16:   d = '{8'h6A, FMT_TLV, 4'd0};
					5'd17:   d = '{8'h5E, FMT_TLV, 4'd0};
					default: d = '{8'h00, FMT_TLV, 4'd0};
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

[sv/nasie_useq.sv]
// microcode sequencer: step counter, control store and branch logic
// depends on nasie_pkg for the control word, control and status structs
module nasie_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  nasie_pkg::stat_t stat,
	output nasie_pkg::ctrl_t ctrl
);

	nasie_pkg::step_t  step_q;
	nasie_pkg::step_t  step_nx;
	nasie_pkg::uword_t w;

	// control store
	always_comb begin
		case (step_q)
			nasie_pkg::STEP_FETCH: w = '{nasie_pkg::A_FETCH, nasie_pkg::BR_DISPATCH,
				nasie_pkg::STEP_FETCH, nasie_pkg::STEP_FETCH};
			nasie_pkg::STEP_SCAN:  w = '{nasie_pkg::A_SCAN, nasie_pkg::BR_SCAN,
				nasie_pkg::STEP_OPEN, nasie_pkg::STEP_UNP};
			nasie_pkg::STEP_OPEN:  w = '{nasie_pkg::A_OPEN, nasie_pkg::BR_DONE,
				nasie_pkg::STEP_FETCH, nasie_pkg::STEP_OPEN};
			nasie_pkg::STEP_LEN:   w = '{nasie_pkg::A_LEN, nasie_pkg::BR_DONE,
				nasie_pkg::STEP_FETCH, nasie_pkg::STEP_LEN};
			nasie_pkg::STEP_BODY:  w = '{nasie_pkg::A_BODY, nasie_pkg::BR_DONE,
				nasie_pkg::STEP_FETCH, nasie_pkg::STEP_BODY};
			nasie_pkg::STEP_UNP:   w = '{nasie_pkg::A_UNP, nasie_pkg::BR_DONE,
				nasie_pkg::STEP_FETCH, nasie_pkg::STEP_UNP};
			default:               w = '{nasie_pkg::A_FETCH, nasie_pkg::BR_DISPATCH,
				nasie_pkg::STEP_FETCH, nasie_pkg::STEP_FETCH};
		endcase
	end

	assign ctrl.act = w.act;

	always_comb begin
		step_nx = step_q;
		case (w.br)
			nasie_pkg::BR_DISPATCH: begin
				if (stat.in_acc) begin
					case (stat.disp_phase)
						nasie_pkg::PH_ID:  step_nx = nasie_pkg::STEP_SCAN;
						nasie_pkg::PH_LEN: step_nx = nasie_pkg::STEP_LEN;
						nasie_pkg::PH_VAL: step_nx = nasie_pkg::STEP_BODY;
						default:           step_nx = nasie_pkg::STEP_UNP;
					endcase
				end
			end
			nasie_pkg::BR_SCAN: begin
				if (stat.scan_end) begin
					step_nx = w.alt;
				end else if (stat.scan_hit) begin
					step_nx = w.tgt;
				end
			end
			nasie_pkg::BR_DONE: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					step_nx = w.tgt;
				end else begin
					step_nx = w.alt;
				end
			end
			default: step_nx = nasie_pkg::STEP_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= nasie_pkg::STEP_FETCH;
		end else begin
			step_q <= step_nx;
		end
	end

endmodule

[sv/nasie_dpath.sv]
// datapath of the matcher: message state, list scan, result build, output register
// depends on nasie_pkg for the element tables and the control and status structs
module nasie_dpath #(
	parameter int LIST_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  nasie_pkg::ctrl_t ctrl,
	output nasie_pkg::stat_t stat,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       msg_kind,
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [4:0]       slot,
	output logic [4:0]       entry,
	output logic [8:0]       offset,
	output logic [7:0]       data_out,
	output logic             ie_start,
	output logic             ie_end,
	output logic             unparsed,
	output logic             truncated,
	output logic             end_of_message
);

	localparam int LW = $clog2(LIST_DEPTH + 1);

	logic [1:0]           kind_q;
	logic [LW-1:0]        list_pos_q;
	nasie_pkg::phase_t    phase_q;
	logic [8:0]           bytes_left_q;
	logic [4:0]           slot_q;
	logic [4:0]           cur_entry_q;
	logic [8:0]           byte_pos_q;
	logic [LW-1:0]        scan_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	nasie_pkg::ie_desc_t  desc_q;
	logic                 out_valid_q;

	logic                 in_acc;
	logic                 out_free;
	logic [LW-1:0]        cnt;
	logic [4:0]           rc;
	nasie_pkg::ie_desc_t  desc;
	logic                 scan_end;
	logic                 scan_hit;
	logic                 commit;

	logic [4:0]           r_slot;
	logic [4:0]           r_entry;
	logic [8:0]           r_off;
	logic [7:0]           r_data;
	logic                 r_start;
	logic                 r_end;
	logic                 r_unp;
	logic                 r_trunc;
	nasie_pkg::phase_t    n_phase;
	logic [8:0]           n_bl;
	logic [8:0]           n_bp;
	logic [4:0]           n_ce;
	logic [LW-1:0]        n_lp;
	logic [4:0]           n_slot;
	logic [3:0]           tv_left;

	assign in_stall = (ctrl.act != nasie_pkg::A_FETCH);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign rc  = nasie_pkg::rom_count(kind_q);
	assign cnt = (LW'(rc) > LW'(LIST_DEPTH)) ? LW'(LIST_DEPTH) : LW'(rc);

	// one list entry examined per scan step
	assign desc     = nasie_pkg::ie_rom(kind_q, scan_q[4:0]);
	assign scan_end = (scan_q >= cnt);
	assign scan_hit = !scan_end && ((desc.fmt == nasie_pkg::FMT_HALF) ?
		(byte_q[7:4] == desc.id[3:0]) : (byte_q == desc.id));

	assign stat.in_acc     = in_acc;
	assign stat.disp_phase = first_byte ? nasie_pkg::PH_ID : phase_q;
	assign stat.scan_hit   = scan_hit;
	assign stat.scan_end   = scan_end;
	assign stat.out_free   = out_free;

	assign commit = out_free && (ctrl.act inside {nasie_pkg::A_OPEN, nasie_pkg::A_LEN,
		nasie_pkg::A_BODY, nasie_pkg::A_UNP});

	assign tv_left = (desc_q.arg != 4'd0) ? (desc_q.arg - 4'd1) : 4'd0;

	always_comb begin
		r_slot  = slot_q;
		r_entry = 5'd0;
		r_off   = 9'd0;
		r_data  = byte_q;
		r_start = 1'b0;
		r_end   = 1'b0;
		r_unp   = 1'b0;
		n_phase = phase_q;
		n_bl    = bytes_left_q;
		n_bp    = byte_pos_q;
		n_ce    = cur_entry_q;
		n_lp    = list_pos_q;
		case (ctrl.act)
			nasie_pkg::A_OPEN: begin
				n_ce    = scan_q[4:0];
				n_lp    = scan_q + LW'(1);
				r_entry = scan_q[4:0];
				r_start = 1'b1;
				n_bp    = 9'd1;
				case (desc_q.fmt)
					nasie_pkg::FMT_HALF: begin
						r_data = byte_q & (nasie_pkg::HALF_ID_MASK | {4'h0, desc_q.arg});
						r_end  = 1'b1;
					end
					nasie_pkg::FMT_TV: begin
						n_bl = {5'd0, tv_left};
						if (tv_left == 4'd0) begin
							r_end = 1'b1;
						end else begin
							n_phase = nasie_pkg::PH_VAL;
						end
					end
					default: n_phase = nasie_pkg::PH_LEN;
				endcase
			end
			nasie_pkg::A_LEN: begin
				r_entry = cur_entry_q;
				r_off   = byte_pos_q;
				n_bl    = {1'b0, byte_q};
				n_bp    = 9'd2;
				if (byte_q == 8'd0) begin
					r_end   = 1'b1;
					n_phase = nasie_pkg::PH_ID;
				end else begin
					n_phase = nasie_pkg::PH_VAL;
				end
			end
			nasie_pkg::A_BODY: begin
				r_entry = cur_entry_q;
				r_off   = byte_pos_q;
				n_bp    = byte_pos_q + 9'd1;
				n_bl    = (bytes_left_q != 9'd0) ? (bytes_left_q - 9'd1) : 9'd0;
				if (n_bl == 9'd0) begin
					r_end   = 1'b1;
					n_phase = nasie_pkg::PH_ID;
				end
			end
			nasie_pkg::A_UNP: begin
				r_unp   = 1'b1;
				n_phase = nasie_pkg::PH_UNP;
			end
			default: begin
			end
		endcase
		n_slot = slot_q;
		if (r_end) begin
			n_slot = slot_q + 5'd1;
			n_bp   = 9'd0;
		end
		r_trunc = last_q && (n_phase == nasie_pkg::PH_LEN || n_phase == nasie_pkg::PH_VAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= 2'd0;
			list_pos_q   <= '0;
			phase_q      <= nasie_pkg::PH_ID;
			bytes_left_q <= 9'd0;
			slot_q       <= 5'd0;
			cur_entry_q  <= 5'd0;
			byte_pos_q   <= 9'd0;
			scan_q       <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				last_q <= last_byte;
				if (first_byte) begin
					kind_q       <= msg_kind;
					list_pos_q   <= '0;
					phase_q      <= nasie_pkg::PH_ID;
					bytes_left_q <= 9'd0;
					slot_q       <= 5'd0;
					cur_entry_q  <= 5'd0;
					byte_pos_q   <= 9'd0;
					scan_q       <= '0;
				end else begin
					scan_q <= list_pos_q;
				end
			end
			if (ctrl.act == nasie_pkg::A_SCAN && !scan_end && !scan_hit) begin
				scan_q <= scan_q + LW'(1);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				// the last item of a message leaves the message state cleared
				if (last_q) begin
					list_pos_q   <= '0;
					phase_q      <= nasie_pkg::PH_ID;
					bytes_left_q <= 9'd0;
					slot_q       <= 5'd0;
					cur_entry_q  <= 5'd0;
					byte_pos_q   <= 9'd0;
				end else begin
					list_pos_q   <= n_lp;
					phase_q      <= n_phase;
					bytes_left_q <= n_bl;
					slot_q       <= n_slot;
					cur_entry_q  <= n_ce;
					byte_pos_q   <= n_bp;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q <= data_byte;
		end
		if (ctrl.act == nasie_pkg::A_SCAN && scan_hit) begin
			desc_q <= desc;
		end
		if (commit) begin
			slot           <= r_slot;
			entry          <= r_entry;
			offset         <= r_off;
			data_out       <= r_data;
			ie_start       <= r_start;
			ie_end         <= r_end;
			unparsed       <= r_unp;
			truncated      <= r_trunc;
			end_of_message <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/nas_optional_ie_matcher.sv]
// top level of the nas optional element matcher
// joins the microcode sequencer nasie_useq and the datapath nasie_dpath
// depends on nasie_pkg
//
// usage: the optional element part of a message enters one byte per item on the
// input channel (in_valid / in_stall) with msg_kind, first_byte and last_byte.
// every accepted item gives exactly one result item on the output channel
// (out_valid / out_stall): element slot, list entry, offset, masked byte and flags.
// first_byte samples msg_kind and restarts matching; after the last_byte item
// the message state is cleared.
// steps: a length or value byte and an unparsed byte go through a fetch step, then
// a result step. an identifier byte goes through a fetch step, then scan steps, one per
// list entry tried, plus one more when the list runs out with no match, then a result
// step. a result appears on out_valid in the cycle after its result step.
// the output register lets the next item be fetched while a result waits; if
// the receiver stalls, the result step holds and in_stall stays high until the
// output register frees.
// reset: asynchronous, active low; clears the message kind, the message state
// and the output valid; the block then waits for its first item.
module nas_optional_ie_matcher #(
	parameter int LIST_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] msg_kind,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] slot,
	output logic [4:0] entry,
	output logic [8:0] offset,
	output logic [7:0] data_out,
	output logic       ie_start,
	output logic       ie_end,
	output logic       unparsed,
	output logic       truncated,
	output logic       end_of_message
);

	nasie_pkg::ctrl_t ctrl;
	nasie_pkg::stat_t stat;

	nasie_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	nasie_dpath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.msg_kind       (msg_kind),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot           (slot),
		.entry          (entry),
		.offset         (offset),
		.data_out       (data_out),
		.ie_start       (ie_start),
		.ie_end         (ie_end),
		.unparsed       (unparsed),
		.truncated      (truncated),
		.end_of_message (end_of_message)
	);

endmodule
